/* design/mrom_pkg.sv */
// mrom_pkg: shared types, constants and codes for the matrix row-op/multiply block
// no dependencies
`default_nettype none
package mrom_pkg;
   localparam int MAX_DIM_DEF = 8;
   localparam int DATA_W = 32;
   localparam logic [31:0] BAD_READ = 32'hFFFE7961;

   typedef enum logic [2:0] {
      OP_WRA = 3'd0, OP_WRB = 3'd1, OP_RDA = 3'd2, OP_SWAP = 3'd3,
      OP_SCALE = 3'd4, OP_ADDS = 3'd5, OP_MUL = 3'd6, OP_NONE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_INDEX = 2'd1, ST_DIM = 2'd2, ST_RSV = 2'd3
   } status_type;

   localparam logic [1:0] CSR_A_ROWS = 2'd0;
   localparam logic [1:0] CSR_A_COLS = 2'd1;
   localparam logic [1:0] CSR_B_ROWS = 2'd2;
   localparam logic [1:0] CSR_B_COLS = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic [2:0]         row_first;
      logic [2:0]         row_second;
      logic [2:0]         column;
      logic signed [31:0] value;
      logic signed [31:0] scale;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [1:0]         status;
      logic [2:0]         out_row;
      logic [2:0]         out_col;
      logic               last;
   } rsp_type;

   // datapath commands from the controller
   typedef enum logic [3:0] {
      DC_IDLE, DC_WRA, DC_WRB, DC_RD, DC_RD2, DC_ROW, DC_MAC, DC_RSP, DC_CLR
   } dcmd_type;

   typedef struct packed {
      dcmd_type   cmd;
      logic [2:0] ra;   // a row
      logic [2:0] rb;   // second a row, or b row
      logic [2:0] ca;   // column
      logic [2:0] cb;   // b column
      logic       first;
   } cmd_type;
endpackage
`default_nettype wire

/* design/mrom_datapath.sv */
// mrom_datapath: matrix stores, multiplier, accumulator and row-op write-back
// depends on mrom_pkg
`default_nettype none
module mrom_datapath #(
   parameter int MAX_DIM = mrom_pkg::MAX_DIM_DEF
) (
   input  wire logic             clock,
   input  wire mrom_pkg::cmd_type cmd,
   input  wire logic [2:0]       op,
   input  wire logic [31:0]      wval,
   input  wire logic [31:0]      scale,
   output logic      [31:0]      rd_data,
   output logic      [31:0]      acc
);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0] mem_a [DEPTH];
   logic [31:0] mem_b [DEPTH];
   logic [31:0] qa_ff, qb_ff, qb2_ff;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] prod;
   logic [AW-1:0] ad_a, ad_b, ad_a2;

   always_comb begin
      ad_a  = AW'(32'(cmd.ra) * MAX_DIM + 32'(cmd.ca));
      ad_a2 = AW'(32'(cmd.rb) * MAX_DIM + 32'(cmd.ca));
      ad_b  = AW'(32'(cmd.rb) * MAX_DIM + 32'(cmd.cb));
   end

   // a read ports: row ra and row rb of a, one of b
   always_ff @(posedge clock) begin
      qa_ff  <= mem_a[ad_a];
      qb2_ff <= mem_a[ad_a2];
      qb_ff  <= mem_b[ad_b];
   end

   assign prod = (cmd.cmd == mrom_pkg::DC_MAC) ? qa_ff * qb_ff
               : ((op == mrom_pkg::OP_SWAP) ? qb2_ff : qb2_ff * scale);

   // write port: clearing pass, element writes and row-op write-back
   always_ff @(posedge clock) begin
      if (cmd.cmd == mrom_pkg::DC_CLR) begin
         mem_a[ad_a] <= '0;
      end else if (cmd.cmd == mrom_pkg::DC_WRA) begin
         mem_a[ad_a] <= wval;
      end else if (cmd.cmd == mrom_pkg::DC_ROW) begin
         unique case (op)
            mrom_pkg::OP_SWAP:  mem_a[ad_a] <= qb2_ff;
            mrom_pkg::OP_SCALE: mem_a[ad_a] <= qa_ff * scale;
            default:            mem_a[ad_a] <= qa_ff + prod;
         endcase
      end
      if (cmd.cmd == mrom_pkg::DC_CLR) begin
         mem_b[ad_b] <= '0;
      end else if (cmd.cmd == mrom_pkg::DC_WRB) begin
         mem_b[ad_b] <= wval;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.cmd == mrom_pkg::DC_MAC) begin
         acc_in = (cmd.first ? 32'd0 : acc_ff) + prod;
      end
   end
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
   assign rd_data = qa_ff;
endmodule
`default_nettype wire

/* design/mrom_ctrl.sv */
// mrom_ctrl: sequencer for element access, row operations and multiply
// depends on mrom_pkg
`default_nettype none
module mrom_ctrl #(
   parameter int MAX_DIM = mrom_pkg::MAX_DIM_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mrom_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mrom_pkg::rsp_type      rsp_word,
   input  wire logic [3:0]        ar, ac, br, bc,
   output mrom_pkg::cmd_type      cmd,
   output logic [2:0]             op,
   output logic [31:0]            wval,
   output logic [31:0]            scale,
   input  wire logic [31:0]       rd_data,
   input  wire logic [31:0]       acc
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001, S_RD   = 9'b000000010, S_RDW = 9'b000000100,
      S_ROWR  = 9'b000001000, S_ROWW = 9'b000010000, S_SWB = 9'b000100000,
      S_MAC   = 9'b001000000, S_MACW = 9'b010000000, S_OUT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   mrom_pkg::req_type rq_ff;
   logic [2:0] i_ff, j_ff, i_in, j_in;
   logic [3:0] k_ff, k_in;
   logic kdel_ff;
   logic ovalid_ff;
   mrom_pkg::rsp_type obuf_ff;
   logic [31:0] swtmp_ff;

   logic [3:0] rows_a, cols_a, rows_b, cols_b;
   assign rows_a = ar; assign cols_a = ac; assign rows_b = br; assign cols_b = bc;

   logic out_free;
   assign out_free = !ovalid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   logic acc_req;
   assign acc_req = req_valid && req_ready;

   logic bad_a, bad_b, bad_r, bad_rr;
   always_comb begin
      bad_a  = ({1'b0, req_word.row_first} >= rows_a) || ({1'b0, req_word.column} >= cols_a);
      bad_b  = ({1'b0, req_word.row_first} >= rows_b) || ({1'b0, req_word.column} >= cols_b);
      bad_r  = {1'b0, req_word.row_first} >= rows_a;
      bad_rr = bad_r || ({1'b0, req_word.row_second} >= rows_a);
   end

   logic push;
   mrom_pkg::rsp_type push_word;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      push = 1'b0;
      push_word = '0;
      push_word.last = 1'b1;
      cmd = '0;
      cmd.cmd = mrom_pkg::DC_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (acc_req) begin
               unique case (req_word.op)
                  mrom_pkg::OP_WRA: begin
                     push = 1'b1;
                     if (bad_a) push_word.status = mrom_pkg::ST_INDEX;
                     else begin
                        cmd.cmd = mrom_pkg::DC_WRA;
                        cmd.ra = req_word.row_first; cmd.ca = req_word.column;
                     end
                  end
                  mrom_pkg::OP_WRB: begin
                     push = 1'b1;
                     if (bad_b) push_word.status = mrom_pkg::ST_INDEX;
                     else begin
                        cmd.cmd = mrom_pkg::DC_WRB;
                        cmd.rb = req_word.row_first; cmd.cb = req_word.column;
                     end
                  end
                  mrom_pkg::OP_RDA: begin
                     if (bad_a) begin
                        push = 1'b1;
                        push_word.status = mrom_pkg::ST_INDEX;
                        push_word.data = mrom_pkg::BAD_READ;
                     end else state_in = S_RD;
                  end
                  mrom_pkg::OP_SWAP, mrom_pkg::OP_ADDS: begin
                     if (bad_rr) begin
                        push = 1'b1; push_word.status = mrom_pkg::ST_INDEX;
                     end else begin
                        state_in = S_ROWR; k_in = '0;
                     end
                  end
                  mrom_pkg::OP_SCALE: begin
                     if (bad_r) begin
                        push = 1'b1; push_word.status = mrom_pkg::ST_INDEX;
                     end else begin
                        state_in = S_ROWR; k_in = '0;
                     end
                  end
                  mrom_pkg::OP_MUL: begin
                     if (cols_a != rows_b) begin
                        push = 1'b1; push_word.status = mrom_pkg::ST_DIM;
                     end else begin
                        state_in = S_MAC; i_in = '0; j_in = '0; k_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            cmd.ra = rq_ff.row_first; cmd.ca = rq_ff.column;
            state_in = S_RDW;
         end
         S_RDW: begin
            push = 1'b1;
            push_word.data = rd_data;
            state_in = S_IDLE;
         end
         // read both rows at column k
         S_ROWR: begin
            cmd.ra = rq_ff.row_first; cmd.rb = rq_ff.row_second; cmd.ca = k_ff[2:0];
            state_in = S_ROWW;
         end
         S_ROWW: begin
            cmd.cmd = mrom_pkg::DC_ROW;
            cmd.ra = rq_ff.row_first; cmd.rb = rq_ff.row_second; cmd.ca = k_ff[2:0];
            state_in = (rq_ff.op == mrom_pkg::OP_SWAP) ? S_SWB : S_ROWR;
            if (rq_ff.op != mrom_pkg::OP_SWAP) begin
               if (k_ff + 4'd1 >= cols_a) begin
                  state_in = S_OUT;
               end else k_in = k_ff + 4'd1;
            end
         end
         S_SWB: begin
            cmd.cmd = mrom_pkg::DC_WRA;
            cmd.ra = rq_ff.row_second; cmd.ca = k_ff[2:0];
            if (k_ff + 4'd1 >= cols_a) state_in = S_OUT;
            else begin
               k_in = k_ff + 4'd1; state_in = S_ROWR;
            end
         end
         // dot product: issue reads for k, accumulate them in the next cycle
         S_MAC: begin
            cmd.ra = i_ff; cmd.ca = k_ff[2:0]; cmd.rb = k_ff[2:0]; cmd.cb = j_ff;
            if (kdel_ff) begin
               cmd.cmd = mrom_pkg::DC_MAC;
               cmd.first = (k_ff == 4'd1);
            end
            if (k_ff >= cols_a) begin
               cmd.cmd = mrom_pkg::DC_MAC;
               cmd.first = (k_ff == 4'd1);
               state_in = S_MACW;
            end else k_in = k_ff + 4'd1;
         end
         S_MACW: begin
            if (out_free) begin
               push = 1'b1;
               push_word.data = acc;
               push_word.out_row = i_ff;
               push_word.out_col = j_ff;
               push_word.last = ({1'b0, i_ff} + 4'd1 >= rows_a)
                             && ({1'b0, j_ff} + 4'd1 >= cols_b);
               k_in = '0;
               if (push_word.last) state_in = S_IDLE;
               else begin
                  state_in = S_MAC;
                  if ({1'b0, j_ff} + 4'd1 >= cols_b) begin
                     j_in = '0; i_in = i_ff + 3'd1;
                  end else j_in = j_ff + 3'd1;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               push = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // pad for swap: second row write uses value of first row
   always_ff @(posedge clock) begin
      if (state_ff == S_ROWW) swtmp_ff <= rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ovalid_ff <= 1'b0;
         kdel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kdel_ff <= (state_ff == S_MAC) && (state_in == S_MAC);
         if (push) ovalid_ff <= 1'b1;
         else if (rsp_ready) ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      if (acc_req) rq_ff <= req_word;
      if (push) obuf_ff <= push_word;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_word = obuf_ff;
   assign op = rq_ff.op;
   assign wval = (state_ff == S_SWB) ? swtmp_ff : req_word.value;
   assign scale = rq_ff.scale;
endmodule
`default_nettype wire

/* design/matrix_row_ops_and_multiply.sv */
// matrix_row_ops_and_multiply: top level, size registers, controller and datapath
// depends on mrom_pkg, mrom_ctrl, mrom_datapath
//
//  channel | direction | handshake             | word
//  req     | in        | req_valid/req_ready   | mrom_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_ready   | mrom_pkg::rsp_type
//  csr     | in        | csr_write_enable      | 4-bit size register
//
// element write, index or size error: response word pushed from idle; an unused
// code gets no response; read: S_RD, S_RDW; row op: S_ROWR, S_ROWW per column
// (swap adds S_SWB), then S_OUT for the result word; multiply: for each product
// entry the single multiply-accumulate walks k (S_MAC), S_MACW holds on rsp stall.
// Synchronous reset clears control and sets each size to MAX_DIM; a clearing pass
// then zeroes all MAX_DIM*MAX_DIM elements of both stores, req_ready low.
`default_nettype none
module matrix_row_ops_and_multiply #(
   parameter int MAX_DIM = mrom_pkg::MAX_DIM_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mrom_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mrom_pkg::rsp_type      rsp_word,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [3:0]        csr_data
);
   logic [3:0] ar_ff, ac_ff, br_ff, bc_ff;
   logic [3:0] ar, ac, br, bc;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ar_ff <= 4'(MAX_DIM); ac_ff <= 4'(MAX_DIM);
         br_ff <= 4'(MAX_DIM); bc_ff <= 4'(MAX_DIM);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mrom_pkg::CSR_A_ROWS: ar_ff <= csr_data;
            mrom_pkg::CSR_A_COLS: ac_ff <= csr_data;
            mrom_pkg::CSR_B_ROWS: br_ff <= csr_data;
            default:              bc_ff <= csr_data;
         endcase
      end
   end

   function automatic logic [3:0] clamp(input logic [3:0] v);
      if (v == 4'd0) return 4'd1;
      if (v > 4'(MAX_DIM)) return 4'(MAX_DIM);
      return v;
   endfunction

   assign ar = clamp(ar_ff); assign ac = clamp(ac_ff);
   assign br = clamp(br_ff); assign bc = clamp(bc_ff);

   // clearing pass after reset, row by row through both stores
   logic [2:0] clr_row_ff, clr_col_ff;
   logic clearing_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
         clr_col_ff <= '0;
         clearing_ff <= 1'b1;
      end else if (clearing_ff) begin
         if ({29'd0, clr_col_ff} == 32'(MAX_DIM - 1)) begin
            clr_col_ff <= '0;
            if ({29'd0, clr_row_ff} == 32'(MAX_DIM - 1)) clearing_ff <= 1'b0;
            else clr_row_ff <= clr_row_ff + 3'd1;
         end else clr_col_ff <= clr_col_ff + 3'd1;
      end
   end

   mrom_pkg::cmd_type cmd_c, cmd;
   logic [2:0] op;
   logic [31:0] wval, scale, rd_data, acc;
   logic ready_c;

   always_comb begin
      req_ready = ready_c && !clearing_ff;
      cmd = cmd_c;
      if (clearing_ff) begin
         cmd.cmd = mrom_pkg::DC_CLR;
         cmd.ra = clr_row_ff; cmd.ca = clr_col_ff;
         cmd.rb = clr_row_ff; cmd.cb = clr_col_ff;
      end
   end

   mrom_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock, .reset,
      .req_valid(req_valid && !clearing_ff), .req_ready(ready_c), .req_word,
      .rsp_valid, .rsp_ready, .rsp_word,
      .ar, .ac, .br, .bc,
      .cmd(cmd_c), .op, .wval, .scale, .rd_data, .acc
   );

   mrom_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
      .clock, .cmd, .op, .wval, .scale, .rd_data, .acc
   );

`ifndef ASSERT_OFF
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_ready) else $error("accepted during clear");
   a_sizes: assert property (@(posedge clock) disable iff (reset)
      (ar != 4'd0) && (bc != 4'd0)) else $error("size clamp");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
`endif
endmodule
`default_nettype wire

/* tb/matrix_row_ops_and_multiply_test.sv */
// matrix_row_ops_and_multiply_test: self-checking bench for the matrix row-op/multiply block
// depends on mrom_pkg and matrix_row_ops_and_multiply
`default_nettype none
module matrix_row_ops_and_multiply_test;
   timeunit 1ns;
   timeprecision 1ps;

   // predicted response words for every request, checked in order
   class matrix_scoreboard;
      logic [31:0]       mat_a [64];
      logic [31:0]       mat_b [64];
      logic [3:0]        size_reg [4];
      mrom_pkg::rsp_type pending [$];
      int                fails;

      function new();
         foreach (mat_a[i]) begin
            mat_a[i] = '0;
            mat_b[i] = '0;
         end
         foreach (size_reg[i]) size_reg[i] = 4'd8;
         fails = 0;
      endfunction

      function int clamp(logic [3:0] v);
         if (v == 0) return 1;
         if (v > 8) return 8;
         return v;
      endfunction

      function void note_size(logic [1:0] idx, logic [3:0] v);
         size_reg[idx] = v;
      endfunction

      function void push(logic [31:0] d, mrom_pkg::status_type st, int r, int c, bit lst);
         mrom_pkg::rsp_type w;
         w.data = d;
         w.status = st;
         w.out_row = r[2:0];
         w.out_col = c[2:0];
         w.last = lst;
         pending.push_back(w);
      endfunction

      // work out the words one accepted request causes
      function void note_request(mrom_pkg::req_type q);
         int ar, ac, br, bc, r1, r2, cl, n, total;
         logic [31:0] t, acc;
         ar = clamp(size_reg[mrom_pkg::CSR_A_ROWS]);
         ac = clamp(size_reg[mrom_pkg::CSR_A_COLS]);
         br = clamp(size_reg[mrom_pkg::CSR_B_ROWS]);
         bc = clamp(size_reg[mrom_pkg::CSR_B_COLS]);
         r1 = q.row_first;
         r2 = q.row_second;
         cl = q.column;
         case (mrom_pkg::op_type'(q.op))
            mrom_pkg::OP_WRA: begin
               if (r1 >= ar || cl >= ac) push(0, mrom_pkg::ST_INDEX, 0, 0, 1);
               else begin
                  mat_a[r1*8+cl] = q.value;
                  push(0, mrom_pkg::ST_OK, 0, 0, 1);
               end
            end
            mrom_pkg::OP_WRB: begin
               if (r1 >= br || cl >= bc) push(0, mrom_pkg::ST_INDEX, 0, 0, 1);
               else begin
                  mat_b[r1*8+cl] = q.value;
                  push(0, mrom_pkg::ST_OK, 0, 0, 1);
               end
            end
            mrom_pkg::OP_RDA: begin
               if (r1 >= ar || cl >= ac) push(mrom_pkg::BAD_READ, mrom_pkg::ST_INDEX, 0, 0, 1);
               else push(mat_a[r1*8+cl], mrom_pkg::ST_OK, 0, 0, 1);
            end
            mrom_pkg::OP_SWAP: begin
               if (r1 >= ar || r2 >= ar) push(0, mrom_pkg::ST_INDEX, 0, 0, 1);
               else begin
                  for (int i = 0; i < ac; i++) begin
                     t = mat_a[r1*8+i];
                     mat_a[r1*8+i] = mat_a[r2*8+i];
                     mat_a[r2*8+i] = t;
                  end
                  push(0, mrom_pkg::ST_OK, 0, 0, 1);
               end
            end
            mrom_pkg::OP_SCALE: begin
               if (r1 >= ar) push(0, mrom_pkg::ST_INDEX, 0, 0, 1);
               else begin
                  for (int i = 0; i < ac; i++) mat_a[r1*8+i] = mat_a[r1*8+i] * q.scale;
                  push(0, mrom_pkg::ST_OK, 0, 0, 1);
               end
            end
            mrom_pkg::OP_ADDS: begin
               if (r1 >= ar || r2 >= ar) push(0, mrom_pkg::ST_INDEX, 0, 0, 1);
               else begin
                  for (int i = 0; i < ac; i++)
                     mat_a[r1*8+i] = mat_a[r1*8+i] + mat_a[r2*8+i] * q.scale;
                  push(0, mrom_pkg::ST_OK, 0, 0, 1);
               end
            end
            mrom_pkg::OP_MUL: begin
               if (ac != br) push(0, mrom_pkg::ST_DIM, 0, 0, 1);
               else begin
                  total = ar * bc;
                  n = 0;
                  for (int i = 0; i < ar; i++)
                     for (int j = 0; j < bc; j++) begin
                        acc = 0;
                        for (int k = 0; k < ac; k++)
                           acc = acc + mat_a[i*8+k] * mat_b[k*8+j];
                        n++;
                        push(acc, mrom_pkg::ST_OK, i, j, n == total);
                     end
               end
            end
            default: ;
         endcase
      endfunction

      // compare one accepted word with the oldest expectation
      function void check_word(mrom_pkg::rsp_type got);
         mrom_pkg::rsp_type w;
         if (pending.size() == 0) begin
            $error("unexpected word data=%h", got.data);
            fails++;
            return;
         end
         w = pending.pop_front();
         if (got.data !== w.data) begin
            $error("data expected %h actual %h", w.data, got.data);
            fails++;
         end
         if (got.status !== w.status) begin
            $error("status expected %0d actual %0d", w.status, got.status);
            fails++;
         end
         if (got.out_row !== w.out_row) begin
            $error("out_row expected %0d actual %0d", w.out_row, got.out_row);
            fails++;
         end
         if (got.out_col !== w.out_col) begin
            $error("out_col expected %0d actual %0d", w.out_col, got.out_col);
            fails++;
         end
         if (got.last !== w.last) begin
            $error("last expected %0d actual %0d", w.last, got.last);
            fails++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   mrom_pkg::req_type req_word;
   logic              rsp_valid;
   logic              rsp_ready;
   mrom_pkg::rsp_type rsp_word;
   logic              csr_write_enable;
   logic [1:0]        csr_index;
   logic [3:0]        csr_data;

   matrix_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   matrix_row_ops_and_multiply dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: random stalls, check each accepted word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_word(rsp_word);
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // send one request word, idling beforehand at random
   task automatic send_word(mrom_pkg::req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(q);
   endtask

   task automatic send_op(mrom_pkg::op_type op, int r1, int r2, int cl, logic [31:0] v,
                          logic [31:0] sc);
      mrom_pkg::req_type q;
      q.op = op;
      q.row_first = r1[2:0];
      q.row_second = r2[2:0];
      q.column = cl[2:0];
      q.value = v;
      q.scale = sc;
      send_word(q);
   endtask

   // wait until every expected word has come, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_size(logic [1:0] idx, logic [3:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      board.note_size(idx, v);
   endtask

   task automatic set_sizes(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
      drain();
      write_size(mrom_pkg::CSR_A_ROWS, ar);
      write_size(mrom_pkg::CSR_A_COLS, ac);
      write_size(mrom_pkg::CSR_B_ROWS, br);
      write_size(mrom_pkg::CSR_B_COLS, bc);
      csr_write_enable <= 1'b0;
   endtask

   // random word, mostly legal indices with random content
   task automatic random_word();
      mrom_pkg::req_type q;
      int ar, ac;
      ar = board.clamp(board.size_reg[mrom_pkg::CSR_A_ROWS]);
      ac = board.clamp(board.size_reg[mrom_pkg::CSR_A_COLS]);
      q.row_first = 3'($urandom);
      q.row_second = 3'($urandom);
      q.column = 3'($urandom);
      q.value = $urandom;
      q.scale = $urandom;
      if ($urandom_range(99) < 8) q.op = mrom_pkg::OP_MUL;
      else q.op = 3'($urandom_range(7));
      if (q.op == mrom_pkg::OP_MUL && $urandom_range(3) != 0) q.op = mrom_pkg::OP_WRA;
      if ($urandom_range(3) != 0) begin
         q.row_first = 3'($urandom_range(ar - 1));
         q.row_second = 3'($urandom_range(ar - 1));
         q.column = 3'($urandom_range(ac - 1));
      end
      if ($urandom_range(3) == 0) q.scale = 32'(int'($urandom_range(7)) - 3);
      send_word(q);
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 35 == 34) begin
            case ($urandom_range(3))
               0: set_sizes(4'd8, 4'd8, 4'd8, 4'd8);
               1: set_sizes(4'd1, 4'd1, 4'd1, 4'd1);
               2: set_sizes(4'd0, 4'd15, 4'd9, 4'd0);
               default: set_sizes(4'($urandom_range(8, 1)), 4'($urandom_range(8, 1)),
                                  4'($urandom_range(8, 1)), 4'($urandom_range(8, 1)));
            endcase
         end
         random_word();
      end
   endtask

   initial begin
      board = new();
      send_idle_pct = 28;
      recv_idle_pct = 88;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every op, index errors and size clamping
      send_op(mrom_pkg::OP_RDA, 7, 0, 7, 0, 0);
      send_op(mrom_pkg::OP_WRA, 0, 0, 0, 32'h7fffffff, 0);
      send_op(mrom_pkg::OP_WRA, 7, 0, 7, 32'h80000000, 0);
      send_op(mrom_pkg::OP_WRA, 1, 0, 0, 32'hffffffff, 0);
      send_op(mrom_pkg::OP_WRB, 0, 0, 0, 32'h00000003, 0);
      send_op(mrom_pkg::OP_WRB, 7, 0, 7, 32'hffffffff, 0);
      send_op(mrom_pkg::OP_RDA, 0, 0, 0, 0, 0);
      send_op(mrom_pkg::OP_SWAP, 0, 7, 0, 0, 0);
      send_op(mrom_pkg::OP_SWAP, 3, 3, 0, 0, 0);
      send_op(mrom_pkg::OP_SCALE, 7, 0, 0, 0, 32'h80000000);
      send_op(mrom_pkg::OP_ADDS, 1, 1, 0, 0, 32'h7fffffff);
      send_op(mrom_pkg::OP_ADDS, 0, 1, 0, 0, 32'hffffffff);
      send_op(mrom_pkg::OP_NONE, 7, 7, 7, 32'hffffffff, 32'hffffffff);
      send_op(mrom_pkg::OP_MUL, 0, 0, 0, 0, 0);
      set_sizes(4'd2, 4'd3, 4'd2, 4'd1);
      send_op(mrom_pkg::OP_WRA, 2, 0, 0, 1, 0);
      send_op(mrom_pkg::OP_WRA, 0, 0, 3, 1, 0);
      send_op(mrom_pkg::OP_RDA, 5, 0, 1, 0, 0);
      send_op(mrom_pkg::OP_SWAP, 0, 4, 0, 0, 0);
      send_op(mrom_pkg::OP_SCALE, 3, 0, 0, 0, 2);
      send_op(mrom_pkg::OP_ADDS, 0, 6, 0, 0, 2);
      send_op(mrom_pkg::OP_WRB, 0, 0, 1, 1, 0);
      send_op(mrom_pkg::OP_MUL, 0, 0, 0, 0, 0);
      set_sizes(4'd0, 4'd15, 4'd15, 4'd0);
      send_op(mrom_pkg::OP_RDA, 0, 0, 7, 0, 0);
      send_op(mrom_pkg::OP_MUL, 0, 0, 0, 0, 0);
      set_sizes(4'd4, 4'd4, 4'd4, 4'd4);

      // random phases with changing idle pattern
      random_phase(100);
      drain();
      send_idle_pct = 88;
      recv_idle_pct = 28;
      random_phase(100);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(85);
      drain();

      if (board.fails == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
